@@ rtl/mhq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhq_pkg
// Shared types and constants for the mutex handoff core with wait queues.
// ----------------------------------------------------------------------------
package mhq_pkg;

  localparam int QUEUE_DEPTH = 64;
  localparam int QA_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QC_W        = $clog2(QUEUE_DEPTH + 1);
  localparam int TID_W       = 6;
  localparam int OP_W        = 2;
  localparam int OC_W        = 3;

  typedef enum logic [OP_W-1:0] {
    OP_LOCK   = 2'd0,
    OP_UNLOCK = 2'd1,
    OP_SIGNAL = 2'd2
  } op_t;

  typedef enum logic [OC_W-1:0] {
    OC_ACQUIRED = 3'd0,
    OC_BLOCKED  = 3'd1,
    OC_HANDOFF  = 3'd2,
    OC_RELEASED = 3'd3,
    OC_SIGNALED = 3'd4,
    OC_FULL     = 3'd5
  } outcome_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_POP  = 1'b1
  } state_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

@@ rtl/mutex_handoff_with_wait_queues_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mutex_handoff_with_wait_queues_core
// Hardware mutex with an entrance queue and a signaled queue. Unlock hands
// the mutex to the signaled head first, then to the entrance head.
// ----------------------------------------------------------------------------
//  channel  ports                                   direction
//  in       in_valid/in_ready, in_operation,        request in
//           in_thread_id
//  out      out_valid/out_ready, out_outcome,       result out
//           out_woken_thread, out_from_signaled,
//           out_lock_held
//
//  lock, signal and free unlock: one cycle per request
//  handoff unlock: waits in ST_POP on the registered queue RAM read
//  an unused operation code is taken and gives no result
//  reset clears held flag, heads and counts; queue RAMs are not cleared
//  a full result register holds off new requests until it is taken
// ----------------------------------------------------------------------------
module mutex_handoff_with_wait_queues_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mhq_pkg::OP_W-1:0]  in_operation,
  input  logic [mhq_pkg::TID_W-1:0] in_thread_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [mhq_pkg::OC_W-1:0]  out_outcome,
  output logic [mhq_pkg::TID_W-1:0] out_woken_thread,
  output logic                      out_from_signaled,
  output logic                      out_lock_held
);

  import mhq_pkg::*;

  state_t           state_r, state_nxt;
  logic             held_r, held_nxt;
  logic             sel_sig_r, sel_sig_nxt;
  logic             out_valid_r, out_valid_nxt;
  outcome_t         outcome_r, outcome_nxt;
  logic [TID_W-1:0] woken_r, woken_nxt;
  logic             from_sig_r, from_sig_nxt;
  logic             held_out_r, held_out_nxt;
  logic             accept;
  logic             load;
  q_cmd_t           ent_cmd, sig_cmd;
  q_stat_t          ent_stat, sig_stat;
  logic [TID_W-1:0] ent_head, sig_head;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt    = state_r;
    held_nxt     = held_r;
    sel_sig_nxt  = sel_sig_r;
    load         = 1'b0;
    outcome_nxt  = outcome_r;
    woken_nxt    = woken_r;
    from_sig_nxt = from_sig_r;
    ent_cmd      = '0;
    sig_cmd      = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          woken_nxt    = '0;
          from_sig_nxt = 1'b0;
          unique case (in_operation)
            OP_LOCK: begin
              load = 1'b1;
              if (!held_r) begin
                held_nxt    = 1'b1;
                outcome_nxt = OC_ACQUIRED;
              end else if (!ent_stat.full) begin
                ent_cmd.push = 1'b1;
                outcome_nxt  = OC_BLOCKED;
              end else begin
                outcome_nxt = OC_FULL;
              end
            end
            OP_UNLOCK: begin
              if (!held_r) begin
                load        = 1'b1;
                outcome_nxt = OC_RELEASED;
              end else if (!sig_stat.empty) begin
                sig_cmd.pop = 1'b1;
                sel_sig_nxt = 1'b1;
                state_nxt   = ST_POP;
              end else if (!ent_stat.empty) begin
                ent_cmd.pop = 1'b1;
                sel_sig_nxt = 1'b0;
                state_nxt   = ST_POP;
              end else begin
                load        = 1'b1;
                held_nxt    = 1'b0;
                outcome_nxt = OC_RELEASED;
              end
            end
            OP_SIGNAL: begin
              load = 1'b1;
              if (!sig_stat.full) begin
                sig_cmd.push = 1'b1;
                outcome_nxt  = OC_SIGNALED;
              end else begin
                outcome_nxt = OC_FULL;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_POP: begin
        load         = 1'b1;
        outcome_nxt  = OC_HANDOFF;
        woken_nxt    = sel_sig_r ? sig_head : ent_head;
        from_sig_nxt = sel_sig_r;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    held_out_nxt  = load ? held_nxt : held_out_r;
    out_valid_nxt = load || (out_valid_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= 1'b0;
      sel_sig_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      sel_sig_r   <= sel_sig_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    outcome_r  <= outcome_nxt;
    woken_r    <= woken_nxt;
    from_sig_r <= from_sig_nxt;
    held_out_r <= held_out_nxt;
  end

  mhq_queue u_entrance (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ent_cmd),
    .push_id (in_thread_id),
    .stat    (ent_stat),
    .head_id (ent_head)
  );

  mhq_queue u_signaled (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (sig_cmd),
    .push_id (in_thread_id),
    .stat    (sig_stat),
    .head_id (sig_head)
  );

  assign out_valid         = out_valid_r;
  assign out_outcome       = outcome_r;
  assign out_woken_thread  = woken_r;
  assign out_from_signaled = from_sig_r;
  assign out_lock_held     = held_out_r;

endmodule

@@ rtl/mhq_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/mhq_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mhq_queue
// FIFO of thread ids: head and count registers around one RAM. A pop
// launches the read of the head entry; the id appears in the following cycle.
// ----------------------------------------------------------------------------
module mhq_queue (
  input  logic                      clk,
  input  logic                      rst_n,
  input  mhq_pkg::q_cmd_t           cmd,
  input  logic [mhq_pkg::TID_W-1:0] push_id,
  output mhq_pkg::q_stat_t          stat,
  output logic [mhq_pkg::TID_W-1:0] head_id
);

  import mhq_pkg::*;

  logic [QA_W-1:0] head_r, head_nxt;
  logic [QC_W-1:0] count_r, count_nxt;
  logic [QC_W:0]   tail_sum;
  logic [QA_W-1:0] tail;

  // tail wraps with one compare since head + count < 2 * depth
  always_comb begin
    tail_sum = (QC_W+1)'(head_r) + (QC_W+1)'(count_r);
    if (tail_sum >= (QC_W+1)'(QUEUE_DEPTH)) begin
      tail_sum = tail_sum - (QC_W+1)'(QUEUE_DEPTH);
    end
    tail = tail_sum[QA_W-1:0];
  end

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == QC_W'(QUEUE_DEPTH));

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.pop) begin
      head_nxt  = (head_r == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
      count_nxt = count_r - 1'b1;
    end else if (cmd.push) begin
      count_nxt = count_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  mhq_ram #(
    .WIDTH (TID_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (tail),
    .wdata (push_id),
    .re    (cmd.pop),
    .raddr (head_r),
    .rdata (head_id)
  );

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the mutex handoff core with wait queues. A short
// directed list covers free and held unlocks, re-lock by the holder, signal
// while free, the unused operation and handoff order. Random bursts follow:
// lock and signal floods that overrun both queues, unlock runs that drain them,
// random-code noise and mixed lock/unlock/signal traffic. Every result is checked
// field by field against a behavioral model of the lock and its two queues,
// or against the hand-written answer of a typed directed row. Both channels
// see random stall bursts, except in calm stretches and in the tail of the run.
// ----------------------------------------------------------------------------
module tb;
  import mhq_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int ITEMS      = 1400;
  localparam int CALM_TAIL  = 150;
  localparam int DRAIN_WAIT = 8;
  localparam int LIMIT      = 500000;

  typedef struct packed {
    outcome_t         outcome;
    logic [TID_W-1:0] woken;
    logic             from_sig;
    logic             held;
  } reply_t;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [TID_W-1:0] tid;
    logic             typed;
    reply_t           reply;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [OP_W-1:0]  in_operation = '0;
  logic [TID_W-1:0] in_thread_id = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [OC_W-1:0]  out_outcome;
  logic [TID_W-1:0] out_woken_thread;
  logic             out_from_signaled;
  logic             out_lock_held;

  // side channel for directed rows whose answer is written out by hand
  logic             row_typed = 1'b0;
  reply_t           row_reply = '0;

  logic             quiet = 1'b0;
  int               stall_left = 0;
  int               cycles = 0;
  int               fails = 0;
  int               sent = 0;
  int               results_seen = 0;
  int               handoffs = 0;
  int               sig_handoffs = 0;
  int               refusals = 0;

  // lock model state
  logic             mutex_held;
  logic [TID_W-1:0] entry_line[$];
  logic [TID_W-1:0] signal_line[$];
  reply_t           awaited_replies[$];

  row_t             plan[21];

  mutex_handoff_with_wait_queues_core i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_operation      (in_operation),
    .in_thread_id      (in_thread_id),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_outcome       (out_outcome),
    .out_woken_thread  (out_woken_thread),
    .out_from_signaled (out_from_signaled),
    .out_lock_held     (out_lock_held)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic reply_t predict_mutex_reply(logic [OP_W-1:0] op, logic [TID_W-1:0] tid);
    reply_t r;
    r = '0;
    case (op)
      OP_LOCK: begin
        if (!mutex_held) begin
          mutex_held = 1'b1;
          r.outcome = OC_ACQUIRED;
        end else if (entry_line.size() < QUEUE_DEPTH) begin
          entry_line.push_back(tid);
          r.outcome = OC_BLOCKED;
        end else begin
          r.outcome = OC_FULL;
        end
      end
      OP_UNLOCK: begin
        if (!mutex_held) begin
          r.outcome = OC_RELEASED;
        end else if (signal_line.size() != 0) begin
          r.woken = signal_line.pop_front();
          r.from_sig = 1'b1;
          r.outcome = OC_HANDOFF;
        end else if (entry_line.size() != 0) begin
          r.woken = entry_line.pop_front();
          r.outcome = OC_HANDOFF;
        end else begin
          mutex_held = 1'b0;
          r.outcome = OC_RELEASED;
        end
      end
      default: begin
        if (signal_line.size() < QUEUE_DEPTH) begin
          signal_line.push_back(tid);
          r.outcome = OC_SIGNALED;
        end else begin
          r.outcome = OC_FULL;
        end
      end
    endcase
    r.held = mutex_held;
    return r;
  endfunction

  // request acceptance, prediction and result check
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      mutex_held = 1'b0;
      entry_line.delete();
      signal_line.delete();
      awaited_replies.delete();
    end else begin
      if (in_valid && in_ready && in_operation != OP_UNUSED) begin
        want = predict_mutex_reply(in_operation, in_thread_id);
        awaited_replies.push_back(row_typed ? row_reply : want);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (out_outcome == OC_HANDOFF) handoffs++;
        if (out_outcome == OC_HANDOFF && out_from_signaled) sig_handoffs++;
        if (out_outcome == OC_FULL) refusals++;
        if (awaited_replies.size() == 0) begin
          $error("result with no request pending: outcome %0d", out_outcome);
          fails++;
        end else begin
          want = awaited_replies.pop_front();
          if (out_outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_outcome);
            fails++;
          end
          if (out_woken_thread !== want.woken) begin
            $error("woken_thread: expected %0d, got %0d", want.woken, out_woken_thread);
            fails++;
          end
          if (out_from_signaled !== want.from_sig) begin
            $error("from_signaled: expected %0d, got %0d", want.from_sig, out_from_signaled);
            fails++;
          end
          if (out_lock_held !== want.held) begin
            $error("lock_held: expected %0d, got %0d", want.held, out_lock_held);
            fails++;
          end
        end
      end
    end
  end

  // result side stall bursts
  always @(posedge clk) begin
    if (quiet) begin
      stall_left <= 0;
      out_ready <= 1'b1;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 15);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(logic [OP_W-1:0] op, logic [TID_W-1:0] tid, logic typed,
                              reply_t reply);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_thread_id <= tid;
    row_typed    <= typed;
    row_reply    <= reply;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (op != OP_UNUSED) sent++;
  endtask

  // kinds: 0-1 noise, 2 lock flood, 3 signal flood, 4-5 unlock run, else mixed
  task automatic run_burst(int kind, int len);
    logic [OP_W-1:0] op;
    int pick;
    if (kind == 2) send_request(OP_LOCK, TID_W'($urandom_range(0, 63)), 1'b0, '0);
    repeat (len) begin
      pick = $urandom_range(0, 9);
      case (kind)
        0, 1:    op = OP_W'($urandom_range(0, 3));
        2:       op = OP_LOCK;
        3:       op = OP_SIGNAL;
        4, 5:    op = OP_UNLOCK;
        default: op = (pick < 4) ? OP_LOCK : (pick < 8) ? OP_UNLOCK : OP_SIGNAL;
      endcase
      send_request(op, TID_W'($urandom_range(0, 63)), 1'b0, '0);
    end
  endtask

  initial begin
    int kind;
    int len;
    plan = '{
      '{OP_UNLOCK, 6'd0,  1'b1, '{OC_RELEASED, 6'd0, 1'b0, 1'b0}},
      '{OP_UNUSED, 6'd63, 1'b0, '0},
      '{OP_LOCK,   6'd0,  1'b1, '{OC_ACQUIRED, 6'd0, 1'b0, 1'b1}},
      '{OP_LOCK,   6'd63, 1'b1, '{OC_BLOCKED,  6'd0, 1'b0, 1'b1}},
      '{OP_LOCK,   6'd0,  1'b1, '{OC_BLOCKED,  6'd0, 1'b0, 1'b1}},
      '{OP_SIGNAL, 6'd42, 1'b1, '{OC_SIGNALED, 6'd0, 1'b0, 1'b1}},
      '{OP_SIGNAL, 6'd63, 1'b1, '{OC_SIGNALED, 6'd0, 1'b0, 1'b1}},
      '{OP_UNLOCK, 6'd0,  1'b0, '0},
      '{OP_UNLOCK, 6'd63, 1'b0, '0},
      '{OP_UNLOCK, 6'd0,  1'b0, '0},
      '{OP_UNLOCK, 6'd0,  1'b0, '0},
      '{OP_UNLOCK, 6'd0,  1'b1, '{OC_RELEASED, 6'd0, 1'b0, 1'b0}},
      '{OP_UNLOCK, 6'd63, 1'b1, '{OC_RELEASED, 6'd0, 1'b0, 1'b0}},
      '{OP_SIGNAL, 6'd21, 1'b0, '0},
      '{OP_UNUSED, 6'd0,  1'b0, '0},
      '{OP_LOCK,   6'd5,  1'b1, '{OC_ACQUIRED, 6'd0, 1'b0, 1'b1}},
      '{OP_UNLOCK, 6'd0,  1'b0, '0},
      '{OP_UNLOCK, 6'd0,  1'b1, '{OC_RELEASED, 6'd0, 1'b0, 1'b0}},
      '{OP_LOCK,   6'd63, 1'b1, '{OC_ACQUIRED, 6'd0, 1'b0, 1'b1}},
      '{OP_UNUSED, 6'd42, 1'b0, '0},
      '{OP_UNLOCK, 6'd0,  1'b1, '{OC_RELEASED, 6'd0, 1'b0, 1'b0}}
    };
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) send_request(plan[i].op, plan[i].tid, plan[i].typed, plan[i].reply);

    // overrun both queues first, then drain them
    run_burst(2, 70);
    run_burst(3, 70);
    run_burst(4, 150);

    while (sent < ITEMS) begin
      quiet = (sent >= ITEMS - CALM_TAIL) || ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      len = (kind >= 2 && kind <= 5) ? $urandom_range(8, 70) : $urandom_range(4, 24);
      run_burst(kind, len);
    end
    in_valid <= 1'b0;

    while (awaited_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("requests sent: %0d, results checked: %0d", sent, results_seen);
    $display("handoffs: %0d (%0d from signaled queue), queue-full refusals: %0d",
             handoffs, sig_handoffs, refusals);
    if (fails == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
